>>> rtl/modinv_pkg.sv
// Package: widths, microcode step and condition codes, control words and the microcode ROM.
`default_nettype none
package modinv_pkg;

  // Field widths.
  localparam int OPW    = 31;               // operand, modulus, inverse
  localparam int CW     = OPW + 2;          // signed Bezout coefficient
  localparam int DCNT_W = $clog2(OPW);      // divider bit counter
  localparam int PC_W   = 4;                // microcode step counter

  // Microcode step addresses.
  localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] S_CHKM  = 4'd1;
  localparam logic [PC_W-1:0] S_DIVGO = 4'd2;
  localparam logic [PC_W-1:0] S_DIVW  = 4'd3;
  localparam logic [PC_W-1:0] S_MUL   = 4'd4;
  localparam logic [PC_W-1:0] S_UPD   = 4'd5;
  localparam logic [PC_W-1:0] S_CHKG  = 4'd6;
  localparam logic [PC_W-1:0] S_OK    = 4'd7;
  localparam logic [PC_W-1:0] S_FAIL  = 4'd8;

  // Branch conditions: true selects tgt_t, false selects tgt_f.
  localparam logic [2:0] C_ALWAYS   = 3'd0;
  localparam logic [2:0] C_IN_VAL   = 3'd1;
  localparam logic [2:0] C_M_ZERO   = 3'd2;
  localparam logic [2:0] C_DIV_BUSY = 3'd3;
  localparam logic [2:0] C_REM_NZ   = 3'd4;
  localparam logic [2:0] C_RP_ONE   = 3'd5;
  localparam logic [2:0] C_OUT_BUSY = 3'd6;

  typedef struct packed {
    logic            in_take;   // ready towards the input channel
    logic            div_go;    // start the serial divider
    logic            mul_go;    // register quotient times coefficient
    logic            upd;       // advance remainder and coefficient pairs
    logic            ld_ok;     // load reduced coefficient into result reg
    logic            ld_fail;   // load a no-inverse result
    logic [2:0]      cond;
    logic [PC_W-1:0] tgt_t;
    logic [PC_W-1:0] tgt_f;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic m_zero;
    logic div_busy;
    logic rem_nz;
    logic rp_one;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '0;
    case (pc)
      S_IDLE: begin
        w.in_take = 1'b1;
        w.cond = C_IN_VAL;   w.tgt_t = S_CHKM;  w.tgt_f = S_IDLE;
      end
      S_CHKM: begin
        w.cond = C_M_ZERO;   w.tgt_t = S_FAIL;  w.tgt_f = S_DIVGO;
      end
      S_DIVGO: begin
        w.div_go = 1'b1;
        w.cond = C_ALWAYS;   w.tgt_t = S_DIVW;  w.tgt_f = S_DIVW;
      end
      S_DIVW: begin
        w.cond = C_DIV_BUSY; w.tgt_t = S_DIVW;  w.tgt_f = S_MUL;
      end
      S_MUL: begin
        w.mul_go = 1'b1;
        w.cond = C_ALWAYS;   w.tgt_t = S_UPD;   w.tgt_f = S_UPD;
      end
      S_UPD: begin
        w.upd = 1'b1;
        w.cond = C_REM_NZ;   w.tgt_t = S_DIVGO; w.tgt_f = S_CHKG;
      end
      S_CHKG: begin
        w.cond = C_RP_ONE;   w.tgt_t = S_OK;    w.tgt_f = S_FAIL;
      end
      S_OK: begin
        w.ld_ok = 1'b1;
        w.cond = C_OUT_BUSY; w.tgt_t = S_OK;    w.tgt_f = S_IDLE;
      end
      S_FAIL: begin
        w.ld_fail = 1'b1;
        w.cond = C_OUT_BUSY; w.tgt_t = S_FAIL;  w.tgt_f = S_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS;   w.tgt_t = S_IDLE;  w.tgt_f = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/modinv_if.sv
// Interfaces: request channel (operand, modulus) and result channel (inverse, flag).
`default_nettype none
interface modinv_in_if import modinv_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [OPW-1:0] operand;
  logic [OPW-1:0] modulus;

  modport source (output valid, output operand, output modulus, input ready);
  modport sink   (input valid, input operand, input modulus, output ready);
endinterface

interface modinv_out_if import modinv_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [OPW-1:0] inverse;
  logic           valid_res;

  modport source (output valid, output inverse, output valid_res, input ready);
  modport sink   (input valid, input inverse, input valid_res, output ready);
endinterface
`default_nettype wire

>>> rtl/modinv_div.sv
// Serial restoring divider: one quotient bit per cycle.
`default_nettype none
module modinv_div import modinv_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           go,
  input  wire logic [OPW-1:0] dividend,
  input  wire logic [OPW-1:0] divisor,
  output logic                busy,
  output logic [OPW-1:0]      quot,
  output logic [OPW-1:0]      rem
);

  logic [OPW-1:0]    rem_r;
  logic [OPW-1:0]    quo_r;
  logic [OPW-1:0]    dvs_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;

  logic [OPW:0]      sh;
  logic [OPW:0]      diff;
  logic              qbit;

  always_comb begin
    sh   = {rem_r, quo_r[OPW-1]};
    diff = sh - {1'b0, dvs_r};
    qbit = ~diff[OPW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (go) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
      cnt_r <= DCNT_W'(OPW - 1);
    end else if (busy_r) begin
      rem_r <= qbit ? diff[OPW-1:0] : sh[OPW-1:0];
      quo_r <= {quo_r[OPW-2:0], qbit};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

>>> rtl/modinv_useq.sv
// Microcode sequencer: step counter, ROM fetch and two-way conditional jump.
`default_nettype none
module modinv_useq import modinv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire stat_t stat,
  output ctrl_t      ctrl
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  always_comb begin
    ctrl = ucode_rom(pc_r);
    case (ctrl.cond)
      C_ALWAYS:   take = 1'b1;
      C_IN_VAL:   take = stat.in_valid;
      C_M_ZERO:   take = stat.m_zero;
      C_DIV_BUSY: take = stat.div_busy;
      C_REM_NZ:   take = stat.rem_nz;
      C_RP_ONE:   take = stat.rp_one;
      C_OUT_BUSY: take = stat.out_busy;
      default:    take = 1'b1;
    endcase
    pc_nxt = take ? ctrl.tgt_t : ctrl.tgt_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/modular_inverse_euclid.sv
// Top level: modular inverse by the extended Euclidean remainder chain.
// Use: a request on in_ch carries operand and modulus; one result follows on
//   out_ch with the inverse in 0..modulus-1 and valid_res set when the two are
//   coprime. Without an inverse (or for modulus zero) inverse is 0, flag 0.
// Handshake: valid/ready on both channels, transfer when both are high.
// Timing: one request at a time; a new request is taken only once the result
//   of the earlier one is loaded. Each of the k remainder steps (k up to about
//   46 for 31-bit values) runs the start, the serial divider, the wait step
//   that sees the divider done, multiply and update.
// Output: the result sits in an output register, so a new request is taken
//   while the receiver stalls; the sequencer only waits at the end of the
//   following request if the previous result has not yet been taken.
// Reset: synchronous, active low; in_ch.ready is held low, the sequencer
//   returns to idle, divider and output register go empty. No state
//   survives between requests.
`default_nettype none
module modular_inverse_euclid import modinv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  modinv_in_if.sink    in_ch,
  modinv_out_if.source out_ch
);

  ctrl_t ctrl;
  stat_t stat;

  // Euclid state: remainder pair, coefficient pair, modulus.
  logic [OPW-1:0]       rp_r, rc_r, m_r;
  logic signed [CW-1:0] cp_r, cc_r;
  logic signed [CW:0]   prod_r;

  // Result register.
  logic [OPW-1:0] inv_r;
  logic           ok_r;
  logic           oval_r;

  logic                 div_busy;
  logic [OPW-1:0]       div_q, div_rem;

  logic signed [OPW+CW:0] prod_full;
  logic signed [CW:0]     ct_full;
  logic [CW-1:0]          m_ext, adj, fixv;
  logic                   in_acc, out_busy, ld_res;

  modinv_useq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // dividend is the older remainder, divisor the newer one
  modinv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (ctrl.div_go),
    .dividend (rp_r),
    .divisor  (rc_r),
    .busy     (div_busy),
    .quot     (div_q),
    .rem      (div_rem)
  );

  // no request is taken while reset is held
  assign in_ch.ready = ctrl.in_take & rst_n;
  assign in_acc      = in_ch.valid & ctrl.in_take & rst_n;
  assign out_busy    = oval_r & ~out_ch.ready;
  assign ld_res      = (ctrl.ld_ok | ctrl.ld_fail) & ~out_busy;

  always_comb begin
    stat.in_valid = in_ch.valid;
    stat.m_zero   = (m_r == '0);
    stat.div_busy = div_busy;
    stat.rem_nz   = (div_rem != '0);
    stat.rp_one   = (rp_r == OPW'(1));
    stat.out_busy = out_busy;
  end

  // Coefficient update: new = older - q * newer. Magnitudes stay within the
  // modulus, so the product fits the narrowed register.
  always_comb begin
    prod_full = $signed({1'b0, div_q}) * cc_r;
    ct_full   = {cp_r[CW-1], cp_r} - prod_r;
  end

  // Bring the final coefficient into 0..m-1: add m if negative, then one
  // compare-and-subtract.
  always_comb begin
    m_ext = {2'b00, m_r};
    adj   = cp_r[CW-1] ? (CW'(cp_r) + m_ext) : CW'(cp_r);
    fixv  = (adj >= m_ext) ? (adj - m_ext) : adj;
  end

  // A first step with operand >= modulus reduces it, since the newer
  // coefficient is still zero; no separate reduction is needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rp_r <= in_ch.operand;
      rc_r <= in_ch.modulus;
      m_r  <= in_ch.modulus;
      cp_r <= CW'(1);
      cc_r <= '0;
    end else if (ctrl.upd) begin
      rp_r <= rc_r;
      rc_r <= div_rem;
      cp_r <= cc_r;
      cc_r <= ct_full[CW-1:0];
    end
    if (ctrl.mul_go) begin
      prod_r <= prod_full[CW:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_res) begin
      inv_r <= ctrl.ld_ok ? fixv[OPW-1:0] : '0;
      ok_r  <= ctrl.ld_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (ld_res) begin
      oval_r <= 1'b1;
    end else if (out_ch.ready) begin
      oval_r <= 1'b0;
    end
  end

  assign out_ch.valid     = oval_r;
  assign out_ch.inverse   = inv_r;
  assign out_ch.valid_res = ok_r;

endmodule
`default_nettype wire

>>> verif/modular_inverse_euclid_tb.sv
// Self-checking testbench for modular_inverse_euclid: directed corners, then random requests.
`timescale 1ns / 100ps
module modular_inverse_euclid_tb;
  import modinv_pkg::*;

  // Largest field value; 2^31-1 is prime, which the corners below rely on.
  localparam logic [OPW-1:0] FIELD_MAX      = {OPW{1'b1}};
  // Consecutive Fibonacci numbers: the longest remainder chain for 31 bits.
  localparam logic [OPW-1:0] FIB_45         = 31'd1134903170;
  localparam logic [OPW-1:0] FIB_46         = 31'd1836311903;
  localparam int             RANDOM_REQS    = 320;
  localparam int             FULL_RATE_REQS = 80;
  // Worst request is the longest remainder chain; allow a wide margin on top.
  localparam int             WATCHDOG_LIMIT = 20000;
  localparam int             SETTLE_CYCLES  = 2000;

  typedef struct {
    logic [OPW-1:0] operand;
    logic [OPW-1:0] modulus;
    logic [OPW-1:0] inverse;
    logic           valid_res;
  } inverse_expect_t;

  logic clk;
  logic rst_n;

  modinv_in_if  in_ch ();
  modinv_out_if out_ch ();

  modular_inverse_euclid dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Expected results, oldest first, one per accepted request.
  inverse_expect_t pending_inverses[$];

  int  mismatch_count;
  int  requests_sent;
  int  results_checked;
  int  coprime_seen;
  int  quiet_cycles;
  int  ready_hold;
  bit  idling_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Extended Euclid on 64-bit signed values: remainders stay below the
  // modulus and the coefficient magnitude does too, so nothing overflows.
  function automatic inverse_expect_t predict_inverse(input logic [OPW-1:0] op,
                                                      input logic [OPW-1:0] md);
    inverse_expect_t res;
    longint          md_l;
    longint          rem_old;
    longint          rem_new;
    longint          quot;
    longint          rem_next;
    longint          coef_old;
    longint          coef_new;
    longint          coef_next;
    res.operand   = op;
    res.modulus   = md;
    res.inverse   = '0;
    res.valid_res = 1'b0;
    // Modulus zero has no inverse at all.
    if (md == '0)
      return res;
    md_l     = md;
    rem_old  = op;
    rem_old  = rem_old % md_l;   // operand at or above the modulus is reduced first
    rem_new  = md_l;
    coef_old = 1;
    coef_new = 0;
    while (rem_new != 0) begin
      quot      = rem_old / rem_new;
      rem_next  = rem_old - quot * rem_new;
      rem_old   = rem_new;
      rem_new   = rem_next;
      coef_next = coef_old - quot * coef_new;
      coef_old  = coef_new;
      coef_new  = coef_next;
    end
    // gcd other than one: no inverse, result field stays zero
    if (rem_old != 1)
      return res;
    if (coef_old < 0)
      coef_old = coef_old + md_l;
    res.inverse   = OPW'(coef_old % md_l);
    res.valid_res = 1'b1;
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Offers one request and returns at the edge where it is taken. valid is
  // left high afterwards so back-to-back requests need no second assignment
  // in the same step; it drops only for a gap or at the end of stimulus.
  task automatic send_request(input logic [OPW-1:0] op, input logic [OPW-1:0] md);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.operand <= op;
    in_ch.modulus <= md;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_inverses.push_back(predict_inverse(op, md));
    requests_sent++;
  endtask

  // Result side back-pressure: random bursts of ready low, none when idling is off.
  always @(posedge clk) begin
    if (!rst_n || !idling_on) begin
      out_ch.ready <= 1'b1;
      ready_hold   <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      if (ready_hold == 1)
        out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= $urandom_range(1, 14);
    end
  end

  // Scoreboard: each taken result against the oldest outstanding request.
  always @(posedge clk) begin
    inverse_expect_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_inverses.size() == 0) begin
        flag_mismatch($sformatf("result with no request outstanding: inverse %0d flag %0b",
                                out_ch.inverse, out_ch.valid_res));
      end else begin
        want = pending_inverses.pop_front();
        results_checked++;
        if (want.valid_res)
          coprime_seen++;
        if (out_ch.inverse !== want.inverse)
          flag_mismatch($sformatf("%0d mod %0d: inverse %0d, wanted %0d", want.operand,
                                  want.modulus, out_ch.inverse, want.inverse));
        if (out_ch.valid_res !== want.valid_res)
          flag_mismatch($sformatf("%0d mod %0d: valid_res %0b, wanted %0b", want.operand,
                                  want.modulus, out_ch.valid_res, want.valid_res));
      end
    end
  end

  // Watchdog: too long without any request or result moving ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, quiet_cycles);
      $display("modular_inverse_euclid_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Corners: zero and one operands, modulus one and zero, shared factors,
  // operand at or above the modulus, the field maxima and the longest chain.
  task automatic test_directed_corners();
    idling_on = 1'b1;
    send_request('0, 31'd1);
    send_request('0, 31'd5);
    send_request('0, FIELD_MAX);
    send_request(31'd1, 31'd1);
    send_request(31'd1, 31'd7);
    send_request(31'd1, FIELD_MAX);
    send_request(FIELD_MAX, 31'd1);
    send_request(31'd12345, 31'd1);
    send_request('0, '0);
    send_request(31'd9, '0);
    send_request(FIELD_MAX, '0);
    send_request(31'd6, 31'd9);
    send_request(FIELD_MAX, FIELD_MAX);
    send_request(FIELD_MAX - 31'd1, FIELD_MAX);
    send_request(31'd3, 31'd7);
    send_request(31'd10, 31'd7);
    send_request(FIELD_MAX, FIELD_MAX - 31'd1);
    send_request(FIB_45, FIB_46);
    send_request(FIB_46, FIB_45);
    send_request(31'd2, 31'h4000_0000);
    send_request(31'd3, 31'h4000_0000);
    send_request(FIELD_MAX, 31'h4000_0000);
  endtask

  // Random mix, weighted towards requests that run long chains or have an inverse.
  task automatic run_random_mix(input int count);
    logic [OPW-1:0] op;
    logic [OPW-1:0] md;
    longint         fib_lo;
    longint         fib_hi;
    longint         fib_tmp;
    longint         factor;
    int             pick;
    int             steps;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        op = OPW'($urandom());
        md = OPW'($urandom_range(1, FIELD_MAX));
      end else if (pick < 60) begin
        // small modulus: operand mostly far above it
        op = OPW'($urandom());
        md = OPW'($urandom_range(1, 1000));
      end else if (pick < 75) begin
        // common factor, never coprime
        factor = $urandom_range(2, 1000);
        op     = OPW'(factor * $urandom_range(0, FIELD_MAX / factor));
        md     = OPW'(factor * $urandom_range(1, FIELD_MAX / factor));
      end else if (pick < 85) begin
        // consecutive Fibonacci pair: deep remainder chain
        fib_lo = 1;
        fib_hi = 1;
        steps  = $urandom_range(10, 44);
        for (int k = 0; k < steps; k++) begin
          fib_tmp = fib_lo + fib_hi;
          fib_lo  = fib_hi;
          fib_hi  = fib_tmp;
        end
        if ($urandom_range(0, 1) == 0) begin
          op = OPW'(fib_lo);
          md = OPW'(fib_hi);
        end else begin
          op = OPW'(fib_hi);
          md = OPW'(fib_lo);
        end
      end else if (pick < 90) begin
        // trivial operands (0 or 1) and modulus one, each mixed with random values
        op = ($urandom_range(0, 2) == 0) ? OPW'($urandom()) : OPW'($urandom_range(0, 1));
        md = ($urandom_range(0, 1) == 0) ? 31'd1 : OPW'($urandom_range(1, FIELD_MAX));
      end else if (pick < 93) begin
        op = OPW'($urandom());
        md = '0;
      end else begin
        // prime modulus: any non-zero reduced operand has an inverse
        op = OPW'($urandom());
        md = FIELD_MAX;
      end
      send_request(op, md);
    end
  endtask

  // Random traffic with idling switched on and off in stretches.
  task automatic test_random_requests();
    for (int blk = 0; blk < RANDOM_REQS / 40; blk++) begin
      idling_on = ($urandom_range(0, 3) != 0);
      run_random_mix(40);
    end
  endtask

  // Last stretch at full rate on both sides.
  task automatic test_full_rate();
    idling_on = 1'b0;
    run_random_mix(FULL_RATE_REQS);
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operand    = '0;
    in_ch.modulus    = '0;
    out_ch.ready     = 1'b0;
    idling_on        = 1'b1;
    mismatch_count   = 0;
    requests_sent    = 0;
    results_checked  = 0;
    coprime_seen     = 0;
    quiet_cycles     = 0;
    ready_hold       = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_random_requests();
    test_full_rate();

    // Drain: wait for every result, then a while longer for any stray one.
    in_ch.valid <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_inverses.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_inverses.size()));

    $display("Ran %0d requests (corners, random mix, full rate); %0d results checked.",
             requests_sent, results_checked);
    $display("%0d results had an inverse, %0d had none; %0d mismatches.",
             coprime_seen, results_checked - coprime_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("modular_inverse_euclid_tb: PASS");
    end else begin
      $display("modular_inverse_euclid_tb: FAIL");
    end
    $finish;
  end

endmodule
